### rtl/imvm_pkg.sv
// shared types and constants of the integer memory value match unit
package imvm_pkg;

  localparam int DataWidth = 64;
  localparam int WordBytes = DataWidth / 8;
  localparam int LaneCount = 4;

  typedef enum logic [3:0] {
    OP_ANY       = 4'd0,
    OP_UPDATE    = 4'd1,
    OP_EQ        = 4'd2,
    OP_NE        = 4'd3,
    OP_GT        = 4'd4,
    OP_LT        = 4'd5,
    OP_RANGE     = 4'd6,
    OP_UNCHANGED = 4'd7,
    OP_CHANGED   = 4'd8,
    OP_INCREASED = 4'd9,
    OP_DECREASED = 4'd10,
    OP_INCBY     = 4'd11,
    OP_DECBY     = 4'd12
  } op_t;

  typedef enum logic [2:0] {
    DT_INT8  = 3'd0,
    DT_INT16 = 3'd1,
    DT_INT32 = 3'd2,
    DT_INT64 = 3'd3,
    DT_ANY   = 3'd4
  } dtype_t;

  localparam logic [2:0] REG_MATCH_OP       = 3'd0;
  localparam logic [2:0] REG_DATA_TYPE      = 3'd1;
  localparam logic [2:0] REG_REVERSE_ENDIAN = 3'd2;
  localparam logic [2:0] REG_USER_LOW       = 3'd3;
  localparam logic [2:0] REG_USER_HIGH      = 3'd4;
  localparam logic [2:0] REG_USER_FLAGS     = 3'd5;

  typedef struct packed {
    logic [3:0]           match_op;
    logic [2:0]           data_type;
    logic                 reverse_endian;
    logic [DataWidth-1:0] user_low;
    logic [DataWidth-1:0] user_high;
    logic [7:0]           user_flags;
  } cfg_t;

  typedef struct packed {
    logic [DataWidth-1:0] memory_word;
    logic [3:0]           bytes_available;
    logic [DataWidth-1:0] old_word;
    logic [7:0]           old_flags;
  } in_t;

  typedef struct packed {
    logic [7:0] type_hits;
    logic [3:0] match_length;
  } out_t;

endpackage

### rtl/imvm_regs.sv
// configuration registers behind the apb-style port
module imvm_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output imvm_pkg::cfg_t     cfg
);

  logic       wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_op       <= imvm_pkg::OP_ANY;
      cfg.data_type      <= imvm_pkg::DT_ANY;
      cfg.reverse_endian <= 1'b0;
      cfg.user_low       <= '0;
      cfg.user_high      <= '0;
      cfg.user_flags     <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        imvm_pkg::REG_MATCH_OP:       cfg.match_op       <= pwdata[3:0];
        imvm_pkg::REG_DATA_TYPE:      cfg.data_type      <= pwdata[2:0];
        imvm_pkg::REG_REVERSE_ENDIAN: cfg.reverse_endian <= pwdata[0];
        imvm_pkg::REG_USER_LOW:       cfg.user_low       <= pwdata;
        imvm_pkg::REG_USER_HIGH:      cfg.user_high      <= pwdata;
        imvm_pkg::REG_USER_FLAGS:     cfg.user_flags     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      imvm_pkg::REG_MATCH_OP:       prdata = {60'd0, cfg.match_op};
      imvm_pkg::REG_DATA_TYPE:      prdata = {61'd0, cfg.data_type};
      imvm_pkg::REG_REVERSE_ENDIAN: prdata = {63'd0, cfg.reverse_endian};
      imvm_pkg::REG_USER_LOW:       prdata = cfg.user_low;
      imvm_pkg::REG_USER_HIGH:      prdata = cfg.user_high;
      imvm_pkg::REG_USER_FLAGS:     prdata = {56'd0, cfg.user_flags};
      default:                      prdata = '0;
    endcase
  end

endmodule

### rtl/imvm_lane.sv
// compare logic for one integer width, signed and unsigned readings
module imvm_lane #(
  parameter int LogBytes = 0
) (
  input  imvm_pkg::cfg_t cfg,
  input  imvm_pkg::in_t  item,
  output logic [1:0]     hit
);

  localparam int NBytes = 1 << LogBytes;
  localparam int W      = 8 * NBytes;

  logic [W-1:0] mem_raw;
  logic [W-1:0] mem_swap;
  logic [W-1:0] mem;
  logic [W-1:0] old;
  logic [W-1:0] ulo;
  logic [W-1:0] uhi;
  logic [W-1:0] inc;
  logic [W-1:0] dec;
  logic         user_op;
  logic         active;
  logic [1:0]   old_ok;
  logic [1:0]   user_ok;

  assign mem_raw = item.memory_word[W-1:0];
  assign old     = item.old_word[W-1:0];
  assign ulo     = cfg.user_low[W-1:0];
  assign uhi     = cfg.user_high[W-1:0];
  assign inc     = old + ulo;
  assign dec     = old - ulo;

  for (genvar i = 0; i < NBytes; i++) begin : g_swap
    assign mem_swap[8*(NBytes-1-i) +: 8] = mem_raw[8*i +: 8];
  end

  assign user_op = (cfg.match_op >= imvm_pkg::OP_EQ) && (cfg.match_op <= imvm_pkg::OP_RANGE);
  // single bytes are never swapped
  assign mem = (cfg.reverse_endian && user_op && (LogBytes > 0)) ? mem_swap : mem_raw;

  assign active = ((cfg.data_type == imvm_pkg::DT_ANY) || (cfg.data_type == 3'(LogBytes)))
                  && (item.bytes_available >= 4'(NBytes));

  assign old_ok  = item.old_flags[2*LogBytes +: 2];
  assign user_ok = cfg.user_flags[2*LogBytes +: 2];

  // bit 0 is the signed reading, bit 1 the unsigned one
  for (genvar s = 0; s < 2; s++) begin : g_sign
    logic [W-1:0] bias;
    logic [W-1:0] m;
    logic [W-1:0] o;
    logic [W-1:0] l;
    logic [W-1:0] h;
    logic         res;

    // flipping the sign bit turns signed order into unsigned order
    assign bias = (s == 0) ? {1'b1, {(W-1){1'b0}}} : '0;
    assign m    = mem ^ bias;
    assign o    = old ^ bias;
    assign l    = ulo ^ bias;
    assign h    = uhi ^ bias;

    always_comb begin
      case (cfg.match_op)
        imvm_pkg::OP_ANY:       res = 1'b1;
        imvm_pkg::OP_UPDATE:    res = old_ok[s];
        imvm_pkg::OP_EQ:        res = user_ok[s] && (mem == ulo);
        imvm_pkg::OP_NE:        res = user_ok[s] && (mem != ulo);
        imvm_pkg::OP_GT:        res = user_ok[s] && (m > l);
        imvm_pkg::OP_LT:        res = user_ok[s] && (m < l);
        imvm_pkg::OP_RANGE:     res = user_ok[s] && (m >= l) && (m <= h);
        imvm_pkg::OP_UNCHANGED: res = old_ok[s] && (mem == old);
        imvm_pkg::OP_CHANGED:   res = old_ok[s] && (mem != old);
        imvm_pkg::OP_INCREASED: res = old_ok[s] && (m > o);
        imvm_pkg::OP_DECREASED: res = old_ok[s] && (m < o);
        imvm_pkg::OP_INCBY:     res = old_ok[s] && user_ok[s] && (mem == inc);
        imvm_pkg::OP_DECBY:     res = old_ok[s] && user_ok[s] && (mem == dec);
        default:                res = 1'b0;
      endcase
    end

    assign hit[s] = active && res;
  end

endmodule

### rtl/integer_memory_value_match_unit.sv
// top level of the integer memory value match unit
//
// A scanner streams memory words on the input channel (in_valid, in_stall,
// in_data): each request carries the word, its readable byte count, the
// value saved earlier for the address and the types that value was valid
// as. For each request one result leaves on the output channel (out_valid,
// out_stall, out_data) with the matching type flags and the byte width of
// the widest match.
// The operation, width selection, byte order and user values sit in
// registers behind the apb port at byte addresses 8*i; write them only
// while no request is in flight.
// A request taken into the input register is compared across the four width
// lanes in parallel, and its result is then captured in the result register.
// Throughput is one request per cycle while the output is not stalled, set by
// that single compare stage; the 64-bit lane's add and compare is the longest path.
// A stalled result holds in the result register while the input register
// can still take one more request; in_stall rises only when both are full.
// Reset clears both valid flags and loads the register defaults
// (operation any, all integer widths).
module integer_memory_value_match_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  imvm_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output imvm_pkg::out_t  out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [5:0]      paddr,
  input  logic [63:0]     pwdata,
  output logic [63:0]     prdata,
  output logic            pready
);

  imvm_pkg::cfg_t cfg;
  imvm_pkg::in_t  s1_data;
  logic           s1_valid;
  logic           s1_move;
  logic           out_move;
  logic [7:0]     flags;
  logic [3:0]     length;

  imvm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_move = !out_valid || !out_stall;
  assign s1_move  = s1_valid && out_move;
  assign in_stall = s1_valid && !out_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  for (genvar k = 0; k < imvm_pkg::LaneCount; k++) begin : g_lane
    imvm_lane #(.LogBytes(k)) u_lane (
      .cfg  (cfg),
      .item (s1_data),
      .hit  (flags[2*k +: 2])
    );
  end

  // widest matching width wins
  always_comb begin
    if (|flags[7:6]) begin
      length = 4'd8;
    end else if (|flags[5:4]) begin
      length = 4'd4;
    end else if (|flags[3:2]) begin
      length = 4'd2;
    end else if (|flags[1:0]) begin
      length = 4'd1;
    end else begin
      length = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_move) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data.type_hits    <= flags;
      out_data.match_length <= length;
    end
  end

  a_len_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.match_length == 4'd0) == (out_data.type_hits == 8'd0)))
    else $error("match length disagrees with match flags");

  a_len_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.match_length == 4'd0 || out_data.match_length == 4'd1 ||
                   out_data.match_length == 4'd2 || out_data.match_length == 4'd4 ||
                   out_data.match_length == 4'd8))
    else $error("match length is not a legal width");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled while a stage is free");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && out_stall) |=> s1_valid)
    else $error("request dropped from input register");

  a_int8_only: assert property (@(posedge clk) disable iff (rst)
    (s1_move && cfg.data_type == imvm_pkg::DT_INT8) |=> (out_data.type_hits[7:2] == 6'd0))
    else $error("wider flags set with int8 selected");

endmodule
